// File: sv/assert_macros.svh
// assertion macros for the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define CBBF_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// condition must never be seen at a rising edge outside reset
`define CBBF_ASSERT_NEVER(label, clk, rst, expr, msg) \
  `CBBF_ASSERT(label, clk, rst, !(expr), msg)

`endif

// File: sv/cbbf_pkg.sv
// shared constants, types and arithmetic helpers for the biquad band-pass core
package cbbf_pkg;

  localparam int STAGES      = 4;
  localparam int FILTER_SETS = 4;
  localparam int COEF_BITS   = 24;
  localparam int DELAY_BITS  = 32;

  localparam int SAMPLE_BITS    = 12;
  localparam int SET_BITS       = 3;
  localparam int COEF_IN_BITS   = 24;
  localparam int WORD_FRAC      = 16;
  localparam int FRAC_SHIFT     = 20;
  // centred sample in q12.16 needs 12 + 16 bits
  localparam int IN_WORD_BITS   = SAMPLE_BITS + WORD_FRAC;
  localparam int WORD_BITS      = (DELAY_BITS > IN_WORD_BITS) ? DELAY_BITS : IN_WORD_BITS;
  localparam int PROD_BITS      = COEF_BITS + WORD_BITS;
  localparam int RND_BITS       = PROD_BITS - FRAC_SHIFT;
  localparam int SUM_BITS       = ((RND_BITS > WORD_BITS) ? RND_BITS : WORD_BITS) + 2;
  localparam int STAGE_IDX_BITS = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int SET_IDX_BITS   = (FILTER_SETS > 1) ? $clog2(FILTER_SETS) : 1;
  localparam int KINDS_PER_STAGE = 3;
  localparam int COEF_DEPTH     = FILTER_SETS * STAGES * KINDS_PER_STAGE;
  localparam int COEF_ADDR_BITS = $clog2(COEF_DEPTH);
  localparam int RES_BITS       = (((DELAY_BITS - WORD_FRAC) > SAMPLE_BITS) ?
                                   (DELAY_BITS - WORD_FRAC) : SAMPLE_BITS) + 2;
  localparam int COEF_WIDE_BITS = 33;

  localparam logic [SET_BITS-1:0] BYPASS_SET = SET_BITS'(FILTER_SETS);

  localparam logic signed [PROD_BITS-1:0] ROUND_HALF =
    PROD_BITS'(64'sd1 <<< (FRAC_SHIFT - 1));
  localparam logic signed [SUM_BITS-1:0] WORD_MAX =
    SUM_BITS'((64'sd1 <<< (DELAY_BITS - 1)) - 64'sd1);
  localparam logic signed [SUM_BITS-1:0] WORD_MIN =
    SUM_BITS'(-(64'sd1 <<< (DELAY_BITS - 1)));
  localparam logic signed [COEF_WIDE_BITS-1:0] COEF_MAX =
    COEF_WIDE_BITS'((64'sd1 <<< (COEF_BITS - 1)) - 64'sd1);
  localparam logic signed [COEF_WIDE_BITS-1:0] COEF_MIN =
    COEF_WIDE_BITS'(-(64'sd1 <<< (COEF_BITS - 1)));
  localparam logic signed [RES_BITS-1:0] CENTER  = RES_BITS'(2048);
  localparam logic signed [RES_BITS-1:0] RES_MAX = RES_BITS'(4095);

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_COEF    = 2'd1,
    OP_ADVANCE = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_GAIN = 2'd0,
    KIND_A1   = 2'd1,
    KIND_A2   = 2'd2,
    KIND_B1   = 2'd3
  } coef_kind_t;

  // controller to datapath
  typedef struct packed {
    logic       capture;
    logic       coef_wr;
    logic       advance;
    logic       step_gain;
    logic       step_a1;
    logic       step_a2;
    logic       step_b1;
    logic       step_sum;
    logic       load_out;
    logic       rd_en;
    logic       rd_next;
    coef_kind_t rd_kind;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bypass;
    logic last_stage;
  } dp_stat_t;

  function automatic logic [COEF_ADDR_BITS-1:0] coef_addr(
    input logic [SET_IDX_BITS-1:0]   set_idx,
    input logic [STAGE_IDX_BITS-1:0] stage_idx,
    input coef_kind_t                kind
  );
    return COEF_ADDR_BITS'((int'(set_idx) * STAGES + int'(stage_idx)) * KINDS_PER_STAGE
                           + int'(kind) - 1);
  endfunction

  function automatic logic signed [DELAY_BITS-1:0] sat_word(
    input logic signed [SUM_BITS-1:0] val
  );
    if (val > WORD_MAX) return DELAY_BITS'(WORD_MAX);
    if (val < WORD_MIN) return DELAY_BITS'(WORD_MIN);
    return DELAY_BITS'(val);
  endfunction

  function automatic logic signed [COEF_BITS-1:0] sat_coef(
    input logic signed [COEF_IN_BITS-1:0] val
  );
    logic signed [COEF_WIDE_BITS-1:0] wide;
    wide = COEF_WIDE_BITS'(val);
    if (wide > COEF_MAX) return COEF_BITS'(COEF_MAX);
    if (wide < COEF_MIN) return COEF_BITS'(COEF_MIN);
    return COEF_BITS'(wide);
  endfunction

endpackage

// File: sv/cbbf_ram.sv
// generic simple dual-port ram with registered read
module cbbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/cbbf_ctrl.sv
// sequencing state machine for the biquad band-pass core
module cbbf_ctrl import cbbf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] opcode,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_GAIN   = 7'b0000010,
    ST_MUL_A1 = 7'b0000100,
    ST_MUL_A2 = 7'b0001000,
    ST_MUL_B1 = 7'b0010000,
    ST_SUM    = 7'b0100000,
    ST_FIN    = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    cmd.rd_kind = KIND_A1;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (opcode_t'(opcode))
            OP_SAMPLE: begin
              cmd.capture = 1'b1;
              state_next  = stat.bypass ? ST_FIN : ST_GAIN;
            end
            OP_COEF:    cmd.coef_wr = 1'b1;
            OP_ADVANCE: cmd.advance = 1'b1;
            default: ;
          endcase
        end
      end
      ST_GAIN: begin
        cmd.step_gain = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rd_kind   = KIND_A1;
        state_next    = ST_MUL_A1;
      end
      ST_MUL_A1: begin
        cmd.step_a1 = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_kind = KIND_A2;
        state_next  = ST_MUL_A2;
      end
      ST_MUL_A2: begin
        cmd.step_a2 = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_kind = KIND_B1;
        state_next  = ST_MUL_B1;
      end
      ST_MUL_B1: begin
        cmd.step_b1 = 1'b1;
        state_next  = ST_SUM;
      end
      ST_SUM: begin
        cmd.step_sum = 1'b1;
        cmd.rd_en    = !stat.last_stage;
        cmd.rd_next  = 1'b1;
        cmd.rd_kind  = KIND_A1;
        state_next   = stat.last_stage ? ST_FIN : ST_MUL_A1;
      end
      ST_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: sv/cbbf_datapath.sv
// coefficient store, delay line, shared multiplier and accumulator
module cbbf_datapath import cbbf_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  dp_cmd_t                        cmd,
  output dp_stat_t                       stat,
  input  logic [SAMPLE_BITS-1:0]         sample,
  input  logic [1:0]                     coef_set,
  input  logic [3:0]                     coef_stage,
  input  logic [1:0]                     coef_kind,
  input  logic signed [COEF_IN_BITS-1:0] coef_value,
  output logic [SAMPLE_BITS-1:0]         filtered,
  output logic [SET_BITS-1:0]            active_set
);

  logic [SET_BITS-1:0]          set_select;
  logic [SAMPLE_BITS-1:0]       sample_q;
  logic                         bypass_q;
  logic [STAGE_IDX_BITS-1:0]    stage_q;
  logic signed [SUM_BITS-1:0]   acc;
  logic signed [RND_BITS-1:0]   p;
  logic signed [DELAY_BITS-1:0] v;
  logic signed [DELAY_BITS-1:0] d0_arr [STAGES];
  logic signed [DELAY_BITS-1:0] d1_arr [STAGES];
  logic signed [COEF_BITS-1:0]  gains [FILTER_SETS];
  logic                         coef_valid [COEF_DEPTH];
  logic                         valid_q;

  logic                         wr_ok, gain_we, ram_we;
  coef_kind_t                   wr_kind;
  logic [COEF_ADDR_BITS-1:0]    waddr, raddr;
  logic [STAGE_IDX_BITS-1:0]    rd_stage;
  logic signed [COEF_BITS-1:0]  coef_wdata;
  logic [COEF_BITS-1:0]         ram_rdata;
  logic signed [COEF_BITS-1:0]  coef_eff;
  logic signed [COEF_BITS-1:0]  mul_c;
  logic signed [WORD_BITS-1:0]  mul_w, x_word;
  logic signed [DELAY_BITS-1:0] d0, d1;
  logic signed [PROD_BITS-1:0]  prod, prod_rnd;
  logic signed [RND_BITS-1:0]   rnd;
  logic signed [SUM_BITS-1:0]   v_sum, y_sum;
  logic signed [DELAY_BITS-1:0] y_word;
  logic signed [DELAY_BITS-WORD_FRAC-1:0] y_int;
  logic signed [RES_BITS-1:0]   res;
  logic [SAMPLE_BITS-1:0]       res_clamped;

  assign stat.bypass     = (set_select >= BYPASS_SET);
  assign stat.last_stage = (stage_q == STAGE_IDX_BITS'(STAGES - 1));

  // coefficient write decode
  assign wr_kind    = coef_kind_t'(coef_kind);
  assign wr_ok      = cmd.coef_wr && (int'(coef_set) < FILTER_SETS);
  assign gain_we    = wr_ok && (wr_kind == KIND_GAIN);
  assign ram_we     = wr_ok && (wr_kind != KIND_GAIN) && (int'(coef_stage) < STAGES);
  assign coef_wdata = sat_coef(coef_value);
  assign waddr      = coef_addr(SET_IDX_BITS'(coef_set), STAGE_IDX_BITS'(coef_stage),
                                wr_kind);

  assign rd_stage = cmd.rd_next ? (stage_q + STAGE_IDX_BITS'(1)) : stage_q;
  assign raddr    = coef_addr(SET_IDX_BITS'(set_select), rd_stage, cmd.rd_kind);

  cbbf_ram #(
    .WIDTH (COEF_BITS),
    .DEPTH (COEF_DEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (coef_wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // never-written entries read as zero
  assign coef_eff = valid_q ? signed'(ram_rdata) : '0;

  // shared multiplier, rounded to 16 fraction bits
  assign x_word   = WORD_BITS'($signed({~sample_q[SAMPLE_BITS-1],
                                        sample_q[SAMPLE_BITS-2:0],
                                        {WORD_FRAC{1'b0}}}));
  assign d0       = d0_arr[stage_q];
  assign d1       = d1_arr[stage_q];
  assign mul_c    = cmd.step_gain ? gains[SET_IDX_BITS'(set_select)] : coef_eff;
  assign mul_w    = cmd.step_gain ? x_word :
                    (cmd.step_a2 ? WORD_BITS'(d1) : WORD_BITS'(d0));
  assign prod     = mul_c * mul_w;
  assign prod_rnd = prod + ROUND_HALF;
  assign rnd      = prod_rnd[PROD_BITS-1:FRAC_SHIFT];

  assign v_sum = acc - SUM_BITS'(p);
  assign y_sum = SUM_BITS'(v) + SUM_BITS'(p) + SUM_BITS'(d1);

  // output scaling and clamp
  assign y_word = acc[DELAY_BITS-1:0];
  assign y_int  = y_word[DELAY_BITS-1:WORD_FRAC];
  assign res    = RES_BITS'(y_int) + CENTER;

  always_comb begin
    if (res[RES_BITS-1]) begin
      res_clamped = '0;
    end else if (res > RES_MAX) begin
      res_clamped = '1;
    end else begin
      res_clamped = res[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set_select <= '0;
      stage_q    <= '0;
      for (int i = 0; i < STAGES; i++) begin
        d0_arr[i] <= '0;
        d1_arr[i] <= '0;
      end
      for (int i = 0; i < FILTER_SETS; i++) begin
        gains[i] <= '0;
      end
      for (int i = 0; i < COEF_DEPTH; i++) begin
        coef_valid[i] <= 1'b0;
      end
    end else begin
      if (cmd.advance) begin
        set_select <= stat.bypass ? '0 : set_select + SET_BITS'(1);
        for (int i = 0; i < STAGES; i++) begin
          d0_arr[i] <= '0;
          d1_arr[i] <= '0;
        end
      end
      if (cmd.capture) begin
        stage_q <= '0;
      end else if (cmd.step_sum) begin
        stage_q          <= stage_q + STAGE_IDX_BITS'(1);
        d1_arr[stage_q]  <= d0;
        d0_arr[stage_q]  <= v;
      end
      if (gain_we) begin
        gains[SET_IDX_BITS'(coef_set)] <= coef_wdata;
      end
      if (ram_we) begin
        coef_valid[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_q <= sample;
      bypass_q <= stat.bypass;
    end
    if (cmd.rd_en) begin
      valid_q <= coef_valid[raddr];
    end
    if (cmd.step_gain) begin
      acc <= SUM_BITS'(rnd);
    end else if (cmd.step_a2) begin
      acc <= v_sum;
    end else if (cmd.step_sum) begin
      acc <= SUM_BITS'(sat_word(y_sum));
    end
    if (cmd.step_a1 || cmd.step_a2 || cmd.step_b1) begin
      p <= rnd;
    end
    if (cmd.step_b1) begin
      v <= sat_word(v_sum);
    end
    if (cmd.load_out) begin
      filtered   <= bypass_q ? sample_q : res_clamped;
      active_set <= set_select;
    end
  end

endmodule

// File: sv/cascaded_biquad_bandpass_filter_core.sv
// top level of the cascaded biquad band-pass filter core
//
//  channel | signals                                       | transaction
//  --------+-----------------------------------------------+--------------------------
//  in      | in_valid, in_ready, opcode, sample, coef_set, | sample, coefficient write
//          | coef_stage, coef_kind, coef_value             | or filter set advance
//  out     | out_valid, out_ready, filtered, active_set    | one per sample transaction
//
// a filtered sample runs from acceptance to out_valid through one gain multiply,
// then four steps per stage through the single shared multiplier and the
// registered coefficient ram read, and then the final output step
// bypass samples go from acceptance straight to the final output step
// coefficient writes, set advances and unused opcodes complete in the accept cycle
// reset is synchronous; coefficient ram entries read as zero until written
// a stalled output holds the core in its final step with in_ready low
module cascaded_biquad_bandpass_filter_core import cbbf_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     opcode,
  input  logic [SAMPLE_BITS-1:0]         sample,
  input  logic [1:0]                     coef_set,
  input  logic [3:0]                     coef_stage,
  input  logic [1:0]                     coef_kind,
  input  logic signed [COEF_IN_BITS-1:0] coef_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [SAMPLE_BITS-1:0]         filtered,
  output logic [SET_BITS-1:0]            active_set
);

  // command and status between sequencer and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: handshakes, step order and output valid
  cbbf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: coefficient store, delays, multiplier, output register
  cbbf_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .sample     (sample),
    .coef_set   (coef_set),
    .coef_stage (coef_stage),
    .coef_kind  (coef_kind),
    .coef_value (coef_value),
    .filtered   (filtered),
    .active_set (active_set)
  );

endmodule

// File: sv/cbbf_checker.sv
// port-level checks for the biquad band-pass core, bound to the top level
`include "assert_macros.svh"

module cbbf_checker import cbbf_pkg::*; (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [1:0]                     opcode,
  input logic [SAMPLE_BITS-1:0]         sample,
  input logic [1:0]                     coef_set,
  input logic [3:0]                     coef_stage,
  input logic [1:0]                     coef_kind,
  input logic signed [COEF_IN_BITS-1:0] coef_value,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [SAMPLE_BITS-1:0]         filtered,
  input logic [SET_BITS-1:0]            active_set
);

  // a stalled result stays put
  `CBBF_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(filtered) && $stable(active_set), "output changed while stalled")

  // a sample transaction keeps the input closed while it is worked on
  `CBBF_ASSERT(a_sample_busy, clk, rst, in_valid && in_ready && (opcode == OP_SAMPLE) |=> !in_ready, "input open right after a sample")

  // writes, set advances and unused opcodes finish in the accept cycle
  `CBBF_ASSERT(a_ctl_quick, clk, rst, in_valid && in_ready && (opcode != OP_SAMPLE) |=> in_ready, "input closed after a non-sample transaction")

  // reported set never beyond bypass
  `CBBF_ASSERT_NEVER(a_set_range, clk, rst, out_valid && (active_set > BYPASS_SET), "active set out of range")

  // nothing comes out straight after reset
  `CBBF_ASSERT(a_reset_quiet, clk, rst, $past(rst) |-> !out_valid, "output valid right after reset")

endmodule

bind cascaded_biquad_bandpass_filter_core cbbf_checker u_cbbf_checker (.*);

// File: tb/sv/cbbf_filter_checker.sv
// transaction monitor, filter predictor and result scoreboard for the biquad core
module cbbf_filter_checker import cbbf_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [1:0]                     opcode,
  input  logic [SAMPLE_BITS-1:0]         sample,
  input  logic [1:0]                     coef_set,
  input  logic [3:0]                     coef_stage,
  input  logic [1:0]                     coef_kind,
  input  logic signed [COEF_IN_BITS-1:0] coef_value,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [SAMPLE_BITS-1:0]         filtered,
  input  logic [SET_BITS-1:0]            active_set,
  output int                             fail_count,
  output int                             pending,
  output int                             checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] filtered;
    logic [SET_BITS-1:0]    active_set;
  } filter_result_t;

  // predictor state, words kept as 64-bit signed integers
  logic [SET_BITS-1:0] chosen_set;
  longint              delay_words   [STAGES][2];
  longint              section_words [FILTER_SETS][STAGES][KINDS_PER_STAGE];
  longint              gain_words    [FILTER_SETS];

  filter_result_t      filtered_q[$];
  filter_result_t      want;
  int                  failures;
  int                  results_seen;

  function automatic longint clamp_signed(input longint x, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  // coefficient (20 fraction bits) times word (16 fraction bits), half rounding up
  function automatic longint coef_times_word(input longint c, input longint w);
    longint hi;
    longint lo;
    hi = w >>> FRAC_SHIFT;
    lo = w & longint'(1048575);
    return c * hi + ((c * lo + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT);
  endfunction

  task automatic clear_delays();
    for (int k = 0; k < STAGES; k++) begin
      delay_words[k][0] = 0;
      delay_words[k][1] = 0;
    end
  endtask

  task automatic reset_predictor();
    chosen_set = '0;
    clear_delays();
    for (int s = 0; s < FILTER_SETS; s++) begin
      gain_words[s] = 0;
      for (int k = 0; k < STAGES; k++)
        for (int j = 0; j < KINDS_PER_STAGE; j++) section_words[s][k][j] = 0;
    end
  endtask

  task automatic filter_sample(input logic [SAMPLE_BITS-1:0] smp, output filter_result_t r);
    longint word;
    longint d0;
    longint d1;
    longint stage_in;
    longint v;
    longint res;
    int     s;
    if (chosen_set < SET_BITS'(FILTER_SETS)) begin
      s = int'(chosen_set);
      word = (longint'(smp) - 2048) * 65536;
      for (int k = 0; k < STAGES; k++) begin
        d0 = delay_words[k][0];
        d1 = delay_words[k][1];
        stage_in = (k == 0) ? coef_times_word(gain_words[s], word) : word;
        v = clamp_signed(stage_in - coef_times_word(section_words[s][k][0], d0)
                         - coef_times_word(section_words[s][k][1], d1), DELAY_BITS);
        word = clamp_signed(v + coef_times_word(section_words[s][k][2], d0) + d1,
                            DELAY_BITS);
        delay_words[k][1] = d0;
        delay_words[k][0] = v;
      end
      res = (word >>> WORD_FRAC) + 2048;
      if (res < 0) res = 0;
      if (res > 4095) res = 4095;
    end else begin
      // bypass set passes the sample through untouched
      res = longint'(smp);
    end
    r.filtered   = SAMPLE_BITS'(res);
    r.active_set = chosen_set;
  endtask

  task automatic apply_transaction();
    filter_result_t r;
    longint         c;
    case (opcode)
      OP_SAMPLE: begin
        filter_sample(sample, r);
        filtered_q.push_back(r);
      end
      OP_COEF: begin
        c = clamp_signed(longint'(coef_value), COEF_BITS);
        if (int'(coef_set) < FILTER_SETS) begin
          if (coef_kind == KIND_GAIN) gain_words[coef_set] = c;
          else if (int'(coef_stage) < STAGES)
            section_words[coef_set][coef_stage][int'(coef_kind) - 1] = c;
        end
      end
      OP_ADVANCE: begin
        if (chosen_set >= SET_BITS'(FILTER_SETS)) chosen_set = '0;
        else chosen_set = chosen_set + SET_BITS'(1);
        clear_delays();
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_predictor();
      filtered_q.delete();
      failures = 0;
      results_seen = 0;
      fail_count <= 0;
      pending <= 0;
      checked <= 0;
    end else begin
      // results first: a result at this edge never belongs to an item taken at it
      if (out_valid && out_ready) begin
        results_seen++;
        if (filtered_q.size() == 0) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display("result %0d arrived with nothing expected: filtered %0d set %0d",
                     results_seen, filtered, active_set);
        end else begin
          want = filtered_q.pop_front();
          if (filtered !== want.filtered || active_set !== want.active_set) begin
            failures++;
            if (failures <= REPORT_LIMIT)
              $display("result %0d: filtered exp %0d got %0d, active_set exp %0d got %0d",
                       results_seen, want.filtered, filtered, want.active_set,
                       active_set);
          end
        end
      end
      if (in_valid && in_ready) apply_transaction();
      fail_count <= failures;
      pending <= filtered_q.size();
      checked <= results_seen;
    end
  end

endmodule

// File: tb/sv/tb_cascaded_biquad_bandpass_filter_core.sv
// stimulus, handshake pacing and verdict for the cascaded biquad band-pass core
module tb_cascaded_biquad_bandpass_filter_core;
  import cbbf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         ITEM_TARGET    = 1750;
  localparam int         IDLE_PCT       = 26;
  localparam int         HOLD_CYCLES    = 400;
  localparam int         TAIL_CYCLES    = 60;   // well past the filter latency
  localparam int         WATCHDOG_LIMIT = 4000;
  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam logic signed [COEF_IN_BITS-1:0] COEF_TOP    = 24'sh7fffff;
  localparam logic signed [COEF_IN_BITS-1:0] COEF_BOTTOM = 24'sh800000;
  localparam logic signed [COEF_IN_BITS-1:0] COEF_ONE    = 24'sh100000;

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_ready;
  logic [1:0]                     opcode;
  logic [SAMPLE_BITS-1:0]         sample;
  logic [1:0]                     coef_set;
  logic [3:0]                     coef_stage;
  logic [1:0]                     coef_kind;
  logic signed [COEF_IN_BITS-1:0] coef_value;
  logic                           out_valid;
  logic                           out_ready;
  logic [SAMPLE_BITS-1:0]         filtered;
  logic [SET_BITS-1:0]            active_set;

  int fail_count;
  int pending;
  int checked;

  // pacing controls shared by the sender and the receiver
  logic calm;
  logic hold_request;

  int counted_items;
  int sample_items;
  int coef_items;
  int advance_items;
  int ignored_items;
  int quiet_cycles;

  cascaded_biquad_bandpass_filter_core u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .sample     (sample),
    .coef_set   (coef_set),
    .coef_stage (coef_stage),
    .coef_kind  (coef_kind),
    .coef_value (coef_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .filtered   (filtered),
    .active_set (active_set)
  );

  cbbf_filter_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .sample     (sample),
    .coef_set   (coef_set),
    .coef_stage (coef_stage),
    .coef_kind  (coef_kind),
    .coef_value (coef_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .filtered   (filtered),
    .active_set (active_set),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // one transaction on the input channel, with random idle cycles ahead of it
  task automatic send_item(input logic [1:0] op, input logic [SAMPLE_BITS-1:0] smp,
                           input logic [1:0] cset, input logic [3:0] cstage,
                           input logic [1:0] kind,
                           input logic signed [COEF_IN_BITS-1:0] val);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    sample     <= smp;
    coef_set   <= cset;
    coef_stage <= cstage;
    coef_kind  <= kind;
    coef_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // writes to a missing stage and the unused opcode do nothing, so they are not counted
    if (op == OP_SAMPLE) begin
      sample_items++;
      counted_items++;
    end else if (op == OP_ADVANCE) begin
      advance_items++;
      counted_items++;
    end else if (op == OP_COEF && (kind == KIND_GAIN || int'(cstage) < STAGES)) begin
      coef_items++;
      counted_items++;
    end else begin
      ignored_items++;
    end
  endtask

  // unused fields are randomised so every input bit toggles
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp);
    send_item(OP_SAMPLE, smp, 2'($urandom), 4'($urandom), 2'($urandom),
              COEF_IN_BITS'($urandom));
  endtask

  task automatic send_coef(input logic [1:0] cset, input logic [3:0] cstage,
                           input logic [1:0] kind,
                           input logic signed [COEF_IN_BITS-1:0] val);
    send_item(OP_COEF, SAMPLE_BITS'($urandom), cset, cstage, kind, val);
  endtask

  task automatic send_advance();
    send_item(OP_ADVANCE, SAMPLE_BITS'($urandom), 2'($urandom), 4'($urandom),
              2'($urandom), COEF_IN_BITS'($urandom));
  endtask

  task automatic send_unused();
    send_item(OP_UNUSED, SAMPLE_BITS'($urandom), 2'($urandom), 4'($urandom),
              2'($urandom), COEF_IN_BITS'($urandom));
  endtask

  // load a whole set with a stable-ish response: |a1| < 1 + a2, a2 < 0.9
  task automatic program_set(input logic [1:0] cset);
    int gain;
    int a2;
    int a1_lim;
    gain = $urandom_range(32768, 1048576);
    if ($urandom_range(0, 3) == 0) gain = -gain;
    // gain writes ignore the stage, so any stage number goes
    send_coef(cset, 4'($urandom_range(0, 15)), KIND_GAIN, COEF_IN_BITS'(gain));
    for (int k = 0; k < STAGES; k++) begin
      a2 = $urandom_range(0, 943718);
      a1_lim = ((1048576 + a2) / 16) * 15;
      send_coef(cset, 4'(k), KIND_A1,
                COEF_IN_BITS'(int'($urandom_range(0, 2 * a1_lim)) - a1_lim));
      send_coef(cset, 4'(k), KIND_A2, COEF_IN_BITS'(a2));
      send_coef(cset, 4'(k), KIND_B1,
                COEF_IN_BITS'(int'($urandom_range(0, 4194304)) - 2097152));
    end
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // receiver: random back-pressure, a calm stretch and one long hold-off
  initial begin : receiver
    logic hold_done;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // watchdog on cycles without any transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_cascaded_biquad_bandpass_filter_core failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int  pick;
    int  burst;
    logic calm_done;
    logic drained;
    calm          = 1'b0;
    hold_request  = 1'b0;
    calm_done     = 1'b0;
    drained       = 1'b0;
    counted_items = 0;
    sample_items  = 0;
    coef_items    = 0;
    advance_items = 0;
    ignored_items = 0;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    opcode     <= OP_SAMPLE;
    sample     <= '0;
    coef_set   <= '0;
    coef_stage <= '0;
    coef_kind  <= KIND_GAIN;
    coef_value <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: zero coefficients give the centre value whatever the sample
    send_sample(12'd0);
    send_sample(12'hfff);
    // extreme coefficient values; a gain write with a stage number that is ignored
    send_coef(2'd0, 4'd15, KIND_GAIN, COEF_TOP);
    send_coef(2'd0, 4'd0, KIND_A1, COEF_BOTTOM);
    send_coef(2'd0, 4'd3, KIND_A2, COEF_TOP);
    send_coef(2'd0, 4'd1, KIND_B1, COEF_ONE);
    send_coef(2'd1, 4'd0, KIND_GAIN, COEF_BOTTOM);
    send_coef(2'd3, 4'd3, KIND_B1, COEF_IN_BITS'($urandom));
    // section writes beyond the last stage must leave the store alone
    send_coef(2'd0, 4'd4, KIND_A1, COEF_TOP);
    send_coef(2'd2, 4'd15, KIND_A2, COEF_BOTTOM);
    send_unused();
    // saturation at both ends of the output range
    send_sample(12'd0);
    send_sample(12'hfff);
    send_sample(12'd2048);
    send_sample(12'd0);
    // walk through every set to bypass, then wrap back with cleared delays
    send_advance();
    send_sample(12'hfff);
    send_advance();
    send_advance();
    send_advance();
    send_sample(12'd0);
    send_sample(12'hfff);
    send_advance();
    send_sample(12'd1234);

    // random phase
    while (counted_items < ITEM_TARGET) begin
      if (!calm_done && counted_items >= 700) begin
        // no idling, and a long receiver stall so the core backs up into the sender
        calm = 1'b1;
        hold_request = 1'b1;
        calm_done = 1'b1;
      end
      if (calm && counted_items >= 1000) calm = 1'b0;
      if (!drained && counted_items >= 1300) begin
        drain_results();
        drained = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        program_set(2'($urandom_range(0, 3)));
      end else if (pick < 7) begin
        // noise write: any value, any stage including missing ones
        send_coef(2'($urandom), 4'($urandom), 2'($urandom), COEF_IN_BITS'($urandom));
      end else if (pick < 13) begin
        send_advance();
      end else if (pick < 14) begin
        send_unused();
      end else if (pick < 17) begin
        // full-scale square wave to push the stages into saturation
        burst = $urandom_range(4, 10);
        for (int i = 0; i < burst; i++) send_sample((i % 2 == 0) ? 12'hfff : 12'd0);
      end else begin
        send_sample(SAMPLE_BITS'($urandom));
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d samples, %0d coefficient writes, %0d set advances, %0d ignored",
             sample_items, coef_items, advance_items, ignored_items);
    $display("%0d results compared, %0d failures, %0d still outstanding",
             checked, fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_cascaded_biquad_bandpass_filter_core passed");
    end else begin
      $display("tb_cascaded_biquad_bandpass_filter_core failed");
    end
    $finish;
  end

endmodule
